/* sv/b64x_pkg.sv */
// ----------------------------------------------------------------------------
// b64x_pkg
// Shared types, register codes and the base64 alphabet lookup for the
// base64 repeating-key XOR decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64x_pkg;

   // Default and upper bound of the key store size in bytes
   localparam int unsigned MAX_KEY_BYTES_DEF = 16;

   localparam int unsigned KEY_REG_W         = 64;
   localparam int unsigned KEY_BYTES_PER_REG = KEY_REG_W / 8;
   localparam int unsigned KEY_LEN_FIELD_W   = 5;
   localparam int unsigned CSR_INDEX_W       = 2;
   localparam int unsigned CSR_DATA_W        = KEY_REG_W;

   localparam int unsigned SEXTET_W = 6;
   localparam int unsigned PHASE_W  = 2;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_LOW    = 2'd0,
      CSR_KEY_HIGH   = 2'd1,
      CSR_KEY_LENGTH = 2'd2
   } csr_index_type;

   // Alphabet character codes
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   typedef struct packed {
      logic                valid;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] data;
   } step_out_type;

   // Map one text character to its six-bit value; padding and anything else is invalid
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      case (c) inside
         [CHAR_UPPER_A:CHAR_UPPER_Z]: s.value = SEXTET_W'(c - CHAR_UPPER_A);
         [CHAR_LOWER_A:CHAR_LOWER_Z]: s.value = SEXTET_W'(c - CHAR_LOWER_A + 8'd26);
         [CHAR_DIGIT_0:CHAR_DIGIT_9]: s.value = SEXTET_W'(c - CHAR_DIGIT_0 + 8'd52);
         CHAR_PLUS:                   s.value = 6'd62;
         CHAR_SLASH:                  s.value = 6'd63;
         default:                     s.valid = 1'b0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

/* sv/b64x_key_regs.sv */
// ----------------------------------------------------------------------------
// b64x_key_regs
// Key configuration registers: key bytes and the effective key length,
// with a byte select for the current key position.
// ----------------------------------------------------------------------------
`default_nettype none

module b64x_key_regs
   import b64x_pkg::*;
#(
   parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
   localparam int unsigned POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
   localparam int unsigned LEN_W = POS_W + 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic [POS_W-1:0]       key_index,
   output logic [7:0]                  key_byte,
   output logic [LEN_W-1:0]            key_len
);

   logic [7:0]                 key_ff [MAX_KEY_BYTES];
   logic [LEN_W-1:0]           key_len_ff;
   logic [LEN_W-1:0]           key_len_in;
   logic [KEY_LEN_FIELD_W-1:0] len_field;

   for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_key
      localparam csr_index_type SEL =
         (i < KEY_BYTES_PER_REG) ? CSR_KEY_LOW : CSR_KEY_HIGH;
      localparam int unsigned LSB = (i % KEY_BYTES_PER_REG) * 8;

      always_ff @(posedge clock) begin
         if (reset) begin
            key_ff[i] <= '0;
         end else if (csr_write_enable && (csr_index == SEL)) begin
            key_ff[i] <= csr_write_data[LSB +: 8];
         end
      end
   end

   // Store the length already clamped to 1..MAX_KEY_BYTES
   always_comb begin
      len_field = csr_write_data[KEY_LEN_FIELD_W-1:0];
      if (len_field == '0) begin
         key_len_in = LEN_W'(1);
      end else if (len_field > KEY_LEN_FIELD_W'(MAX_KEY_BYTES)) begin
         key_len_in = LEN_W'(MAX_KEY_BYTES);
      end else begin
         key_len_in = LEN_W'(len_field);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= LEN_W'(1);
      end else if (csr_write_enable && (csr_index == CSR_KEY_LENGTH)) begin
         key_len_ff <= key_len_in;
      end
   end

   assign key_byte = key_ff[key_index];
   assign key_len  = key_len_ff;

endmodule

`default_nettype wire

/* sv/b64x_step.sv */
// ----------------------------------------------------------------------------
// b64x_step
// Decoder state and the per-character step: sextet lookup, bit packing,
// key position update and the stop flag.
// ----------------------------------------------------------------------------
`default_nettype none

module b64x_step
   import b64x_pkg::*;
#(
   parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
   localparam int unsigned POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
   localparam int unsigned LEN_W = POS_W + 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic [7:0]       text_char,
   input  wire logic             end_of_message,
   input  wire logic [7:0]       key_byte,
   input  wire logic [LEN_W-1:0] key_len,
   output logic [POS_W-1:0]      key_index,
   output step_out_type          step_out
);

   // Only the last sextet is kept: at most six bits are ever pending
   logic [SEXTET_W-1:0] acc_ff, acc_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                stopped_ff, stopped_in;

   sextet_type       sx;
   logic [POS_W-1:0] pos_eff;
   logic [LEN_W-1:0] pos_inc;
   logic [POS_W-1:0] pos_next;
   logic [7:0]       data;
   logic             emit;

   always_comb begin
      sx       = sextet_of(text_char);
      pos_eff  = ({1'b0, pos_ff} >= key_len) ? '0 : pos_ff;
      pos_inc  = {1'b0, pos_eff} + LEN_W'(1);
      pos_next = (pos_inc >= key_len) ? '0 : pos_inc[POS_W-1:0];
      emit     = !stopped_ff && sx.valid && (phase_ff != '0);

      case (phase_ff)
         2'd1:    data = {acc_ff[1:0], sx.value};
         2'd2:    data = {acc_ff[3:0], sx.value[5:2]};
         2'd3:    data = {acc_ff[5:0], sx.value[5:4]};
         default: data = '0;
      endcase
   end

   always_comb begin
      acc_in     = acc_ff;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      stopped_in = stopped_ff;
      if (end_of_message) begin
         acc_in     = '0;
         phase_in   = '0;
         pos_in     = '0;
         stopped_in = 1'b0;
      end else if (!stopped_ff) begin
         if (!sx.valid) begin
            stopped_in = 1'b1;
         end else begin
            acc_in = sx.value;
            if (emit) begin
               phase_in = phase_ff - PHASE_W'(1);
               pos_in   = pos_next;
            end else begin
               // six bits now pending
               phase_in = PHASE_W'(3);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         phase_ff   <= '0;
         pos_ff     <= '0;
         stopped_ff <= 1'b0;
      end else if (advance) begin
         acc_ff     <= acc_in;
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         stopped_ff <= stopped_in;
      end
   end

   assign key_index     = pos_eff;
   assign step_out.emit = emit;
   assign step_out.data = data ^ key_byte;

endmodule

`default_nettype wire

/* sv/base64_xor_key_decoder.sv */
// Base64 decoder with repeating-key XOR. One text character is taken per
// cycle while req_stall is low; a character enters an input register, is
// decoded and packed with the pending bits combinationally, and its byte (if
// it completes one) is written to the result register when the character
// leaves the input register, which raises rsp_valid. Throughput is one
// character per clock; it drops only while a finished byte is held by
// rsp_stall and the next character also yields a byte. The key (up to
// MAX_KEY_BYTES bytes) and its length must be written through the csr_
// port only while no transaction is in flight; the block does not enforce
// this. A character outside the alphabet, padding included, silences the
// decoder until a character with end_of_message set clears the message
// state.
`default_nettype none

module base64_xor_key_decoder
   import b64x_pkg::*;
#(
   parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
   localparam int unsigned POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
   localparam int unsigned LEN_W = POS_W + 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_text_char,
   input  wire logic                   req_end_of_message,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_plain_byte
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_eom_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;

   logic             req_accept;
   logic             out_free;
   logic             s1_fire;
   logic [POS_W-1:0] key_index;
   logic [7:0]       key_byte;
   logic [LEN_W-1:0] key_len;
   step_out_type     step_out;

   b64x_key_regs #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES)
   ) u_key_regs (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .key_index       (key_index),
      .key_byte        (key_byte),
      .key_len         (key_len)
   );

   b64x_step #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_fire),
      .text_char     (s1_char_ff),
      .end_of_message(s1_eom_ff),
      .key_byte      (key_byte),
      .key_len       (key_len),
      .key_index     (key_index),
      .step_out      (step_out)
   );

   // Hold the character only when it makes a byte and the result slot is busy
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && (!step_out.emit || out_free);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && step_out.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_char_ff <= req_text_char;
         s1_eom_ff  <= req_end_of_message;
      end
      if (s1_fire && step_out.emit) begin
         rsp_byte_ff <= step_out.data;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_byte = rsp_byte_ff;

endmodule

`default_nettype wire

/* sv/b64x_checker.sv */
// ----------------------------------------------------------------------------
// b64x_checker
// Port-level checks for the base64 repeating-key XOR decoder, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b64x_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_plain_byte
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_plain_byte))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Input backs up only behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result side is free");

   // A fresh result comes from an input transaction accepted earlier
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching input transaction");

endmodule

bind base64_xor_key_decoder b64x_checker u_b64x_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_plain_byte(rsp_plain_byte)
);

`default_nettype wire
